@@ design/grrt_pkg.sv @@
package grrt_pkg;

   localparam int REGION_COUNT     = 16;
   localparam int OFFSET_BITS      = 24;
   localparam int MAX_REGION_BYTES = 16777216;
   localparam int TAG_W            = 8;
   localparam int IDX_W            = $clog2(REGION_COUNT + 1);
   localparam int SIZE_W           = $clog2(MAX_REGION_BYTES + 1);
   localparam logic [31:0] OFF_MASK = 32'((64'd1 << OFFSET_BITS) - 64'd1);

   typedef enum logic [2:0] {
      KIND_REGISTER   = 3'd0,
      KIND_UNREGISTER = 3'd1,
      KIND_ENC_OFFSET = 3'd2,
      KIND_ENC_HOST   = 3'd3,
      KIND_RESOLVE    = 3'd4,
      KIND_CLEAR      = 3'd5,
      KIND_RSVD6      = 3'd6,
      KIND_RSVD7      = 3'd7
   } kind_type;

   typedef enum logic [3:0] {
      ST_OK           = 4'd0,
      ST_NULL         = 4'd1,
      ST_BAD_ARG      = 4'd2,
      ST_BAD_REGION   = 4'd3,
      ST_IN_USE       = 4'd4,
      ST_OVERLAP      = 4'd5,
      ST_TOO_LARGE    = 4'd6,
      ST_WRAP         = 4'd7,
      ST_UNREGISTERED = 4'd8,
      ST_OUT_OF_RANGE = 4'd9,
      ST_MISALIGNED   = 4'd10,
      ST_NOT_FOUND    = 4'd11
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_CHECK,
      S_DONE
   } state_type;

   // scan unit request / reply
   typedef struct packed {
      logic        go;
      logic        host_mode;  // 1: find entry holding addr, 0: overlap search
      logic [63:0] lo;
      logic [63:0] hi;
   } scan_req_type;

   typedef struct packed {
      logic             done;
      logic             hit;
      logic [IDX_W-1:0] tag;
   } scan_rsp_type;

endpackage

@@ design/guest_reference_region_table_unit.sv @@
// Sequence: resolve and encode offset pass through scan, then read and check;
//   register scans the entries, then reports from the done state; host-address
//   encode scans, then reads and checks (the scan tests one entry per cycle).
// Throughput: one word at a time; busy stays high until the result strobe.
// Unregister, clear and unknown kinds go from scan back to idle and give no result.
// Reset (synchronous, active high) clears all entry valid bits and control;
// region storage holds garbage until written. Receiver cannot stall.
module guest_reference_region_table_unit
   import grrt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [2:0]    req_kind,
   input  logic [7:0]    req_region_tag,
   input  logic [63:0]   req_host_address,
   input  logic [31:0]   req_region_size,
   input  logic [31:0]   req_region_offset,
   input  logic [31:0]   req_access_size,
   input  logic [31:0]   req_alignment,
   input  logic [31:0]   req_guest_reference,
   input  logic          req_null_allowed,
   output logic          rsp_strobe,
   output logic          rsp_ok,
   output logic [3:0]    rsp_status,
   output logic [31:0]   rsp_reference_out,
   output logic [63:0]   rsp_host_address_out,
   output logic [7:0]    rsp_tag_reported,
   output logic [31:0]   rsp_offset_reported
);

   // region storage: valid bits in flops, payload in arrays
   logic [REGION_COUNT:1] valid_ff;
   logic [63:0]           start_mem [1:REGION_COUNT];
   logic [63:0]           end_mem   [1:REGION_COUNT];
   logic [SIZE_W-1:0]     size_mem  [1:REGION_COUNT];

   state_type state_ff, state_in;

   // captured request word
   kind_type    kind_ff;
   logic [7:0]  tag_ff;
   logic [63:0] host_ff;
   logic [31:0] size_ff, off_ff, acc_ff, align_ff;
   logic        nullok_ff;
   logic [63:0] end_ff;
   logic        wrap_ff;

   // entry lookup, registered reads
   logic [IDX_W-1:0]  rd_idx;
   logic [IDX_W-1:0]  scan_tag;
   logic [63:0]       rd_start_ff, rd_end_ff;
   logic [SIZE_W-1:0] rd_size_ff;

   scan_req_type scan_req;
   scan_rsp_type scan_rsp;

   // resolved tag / offset for the check step
   logic [7:0]  ctag_ff, ctag_in;
   logic [31:0] coff_ff, coff_in;
   logic        found_ff, found_in;

   logic        r_str_in, r_ok_in;
   status_type  r_st_in;
   logic [31:0] r_ref_in, r_off_in;
   logic [63:0] r_host_in;
   logic [7:0]  r_tag_in;
   logic        reg_wr;

   logic        accept;
   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   grrt_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .req      (scan_req),
      .valid    (valid_ff),
      .rd_tag   (scan_tag),
      .rd_start (rd_start_ff),
      .rd_end   (rd_end_ff),
      .rsp      (scan_rsp)
   );

   // one read port: scan address while scanning, else the check tag
   assign rd_idx = (state_ff == S_SCAN) ? scan_tag : IDX_W'(ctag_in);

   always_ff @(posedge clock) begin
      if (rd_idx >= IDX_W'(1) && rd_idx <= IDX_W'(REGION_COUNT)) begin
         rd_start_ff <= start_mem[rd_idx];
         rd_end_ff   <= end_mem[rd_idx];
         rd_size_ff  <= size_mem[rd_idx];
      end
      if (reg_wr) begin
         start_mem[tag_ff[IDX_W-1:0]] <= host_ff;
         end_mem[tag_ff[IDX_W-1:0]]   <= end_ff;
         size_mem[tag_ff[IDX_W-1:0]]  <= size_ff[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_type'(req_kind);
         tag_ff    <= req_region_tag;
         host_ff   <= req_host_address;
         size_ff   <= req_region_size;
         off_ff    <= req_region_offset;
         acc_ff    <= req_access_size;
         align_ff  <= req_alignment;
         nullok_ff <= req_null_allowed;
         {wrap_ff, end_ff} <= {1'b0, req_host_address} + {33'd0, req_region_size};
      end
      ctag_ff  <= ctag_in;
      coff_ff  <= coff_in;
      found_ff <= found_in;
   end

   // pre-scan checks
   logic tag_ok, reg_pre_fail, enc_host_pre;
   logic [7:0] ref_tag;
   logic [31:0] ref_off;
   assign tag_ok  = (tag_ff != 8'd0) && (tag_ff <= 8'(REGION_COUNT));
   assign ref_tag = 8'(req_guest_reference >> OFFSET_BITS);
   assign ref_off = req_guest_reference & OFF_MASK;
   assign reg_pre_fail = !tag_ok || host_ff == 64'd0 || size_ff == 32'd0
                         || size_ff > 32'(MAX_REGION_BYTES) || valid_ff[tag_ff[IDX_W-1:0]]
                         || wrap_ff;
   assign enc_host_pre = (acc_ff == 32'd0) || (host_ff == 64'd0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_SCAN;
         S_SCAN: begin
            unique case (kind_ff)
               KIND_REGISTER:
                  if (reg_pre_fail || scan_rsp.done) state_in = S_DONE;
               KIND_ENC_HOST:
                  if (enc_host_pre || (scan_rsp.done && !scan_rsp.hit)) state_in = S_DONE;
                  else if (scan_rsp.done) state_in = S_READ;
               KIND_ENC_OFFSET, KIND_RESOLVE: state_in = S_READ;
               default: state_in = S_IDLE;
            endcase
         end
         S_READ:  state_in = S_CHECK;
         S_CHECK: state_in = S_IDLE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // scan start: first cycle after accept
   logic first_ff;
   always_ff @(posedge clock) begin
      if (reset) first_ff <= 1'b0;
      else       first_ff <= accept;
   end

   always_comb begin
      scan_req.go        = first_ff && ((kind_ff == KIND_REGISTER && !reg_pre_fail)
                           || (kind_ff == KIND_ENC_HOST && !enc_host_pre));
      scan_req.host_mode = (kind_ff == KIND_ENC_HOST);
      scan_req.lo        = host_ff;
      scan_req.hi        = end_ff;
   end

   // outputs / check datapath
   logic        fits, in_rng, misal, align_bad;
   logic [63:0] host_sum;
   logic [31:0] remain;
   always_comb begin
      remain    = 32'(rd_size_ff) - coff_ff;
      fits      = (coff_ff < 32'(rd_size_ff)) && (acc_ff <= remain);
      in_rng    = (coff_ff <= OFF_MASK) && fits;
      host_sum  = rd_start_ff + {32'd0, coff_ff};
      misal     = (host_sum[31:0] & (align_ff - 32'd1)) != 32'd0;
      align_bad = (align_ff == 32'd0) || ((align_ff & (align_ff - 32'd1)) != 32'd0);
   end

   always_comb begin
      ctag_in   = ctag_ff;
      coff_in   = coff_ff;
      found_in  = found_ff;
      r_str_in  = 1'b0;
      r_ok_in   = 1'b0;
      r_st_in   = ST_OK;
      r_ref_in  = '0;
      r_host_in = '0;
      r_tag_in  = '0;
      r_off_in  = '0;
      reg_wr    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (kind_type'(req_kind) == KIND_RESOLVE) begin
                  ctag_in = ref_tag;
                  coff_in = ref_off;
               end else begin
                  ctag_in = req_region_tag;
                  coff_in = req_region_offset;
               end
            end
         end
         S_SCAN: begin
            // scan reply lasts one cycle: keep hit and tag; rd_start_ff still
            // holds the entry being reported
            if (scan_rsp.done) begin
               found_in = scan_rsp.hit;
               ctag_in  = 8'(scan_rsp.tag);
               if (kind_ff == KIND_ENC_HOST)
                  coff_in = 32'(host_ff - rd_start_ff);
            end
         end
         S_DONE: begin
            r_str_in = (kind_ff == KIND_REGISTER) || (kind_ff == KIND_ENC_HOST);
            if (kind_ff == KIND_REGISTER) begin
               r_tag_in = tag_ff;
               if (!tag_ok || host_ff == 64'd0 || size_ff == 32'd0)
                  r_st_in = ST_BAD_ARG;
               else if (size_ff > 32'(MAX_REGION_BYTES))
                  r_st_in = ST_TOO_LARGE;
               else if (valid_ff[tag_ff[IDX_W-1:0]])
                  r_st_in = ST_IN_USE;
               else if (wrap_ff)
                  r_st_in = ST_WRAP;
               else if (found_ff) begin
                  r_st_in  = ST_OVERLAP;
                  r_tag_in = ctag_ff;
               end else begin
                  r_ok_in = 1'b1;
                  reg_wr  = 1'b1;
               end
            end else begin
               if (acc_ff == 32'd0)
                  r_st_in = ST_BAD_ARG;
               else if (host_ff == 64'd0) begin
                  r_st_in = ST_NULL;
                  r_ok_in = 1'b1;
               end else
                  r_st_in = ST_NOT_FOUND;
            end
         end
         S_CHECK: begin
            r_str_in = 1'b1;
            r_tag_in = ctag_ff;
            r_off_in = coff_ff;
            if (kind_ff == KIND_RESOLVE) begin
               if (acc_ff == 32'd0 || align_bad)
                  r_st_in = ST_BAD_ARG;
               else if (ctag_ff == 8'd0 && coff_ff == 32'd0) begin
                  r_st_in  = ST_NULL;
                  r_ok_in  = nullok_ff;
               end else if (ctag_ff == 8'd0 || ctag_ff > 8'(REGION_COUNT))
                  r_st_in = ST_BAD_REGION;
               else if (!valid_ff[ctag_ff[IDX_W-1:0]])
                  r_st_in = ST_UNREGISTERED;
               else if (!fits)
                  r_st_in = ST_OUT_OF_RANGE;
               else if (misal)
                  r_st_in = ST_MISALIGNED;
               else begin
                  r_ok_in   = 1'b1;
                  r_host_in = host_sum;
               end
            end else begin
               if (acc_ff == 32'd0)
                  r_st_in = ST_BAD_ARG;
               else if (ctag_ff == 8'd0 || ctag_ff > 8'(REGION_COUNT))
                  r_st_in = ST_BAD_REGION;
               else if (!valid_ff[ctag_ff[IDX_W-1:0]])
                  r_st_in = ST_UNREGISTERED;
               else if (!in_rng)
                  r_st_in = ST_OUT_OF_RANGE;
               else begin
                  r_ok_in  = 1'b1;
                  r_ref_in = 32'({24'd0, ctag_ff} << OFFSET_BITS) | coff_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= r_str_in;
         if (reg_wr)
            valid_ff[tag_ff[IDX_W-1:0]] <= 1'b1;
         if (state_ff == S_SCAN && kind_ff == KIND_UNREGISTER && tag_ok)
            valid_ff[tag_ff[IDX_W-1:0]] <= 1'b0;
         if (state_ff == S_SCAN && kind_ff == KIND_CLEAR)
            valid_ff <= '0;
      end
      rsp_ok               <= r_ok_in;
      rsp_status           <= r_st_in;
      rsp_reference_out    <= r_ref_in;
      rsp_host_address_out <= r_host_in;
      rsp_tag_reported     <= r_tag_in;
      rsp_offset_reported  <= r_off_in;
   end

endmodule

@@ design/grrt_scan.sv @@
module grrt_scan
   import grrt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  scan_req_type            req,
   input  logic [REGION_COUNT:1]   valid,
   output logic [IDX_W-1:0]        rd_tag,
   input  logic [63:0]             rd_start,
   input  logic [63:0]             rd_end,
   output scan_rsp_type            rsp
);

   // One entry per cycle, tag order; rd data arrives in the cycle after rd_tag.
   logic                busy_ff, busy_in;
   logic                chk_ff, chk_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    chk_tag_ff, chk_tag_in;
   logic                match;
   logic                last;

   assign rd_tag = cur_ff;
   assign last   = (cur_ff == IDX_W'(REGION_COUNT));

   always_comb begin
      if (req.host_mode)
         match = (req.lo >= rd_start) && (req.lo < rd_end);
      else
         match = (req.lo < rd_end) && (rd_start < req.hi);
      match = match && valid[chk_tag_ff];
   end

   always_comb begin
      busy_in    = busy_ff;
      cur_in     = cur_ff;
      chk_in     = 1'b0;
      chk_tag_in = cur_ff;
      rsp        = '0;
      rsp.tag    = chk_tag_ff;
      if (req.go) begin
         busy_in = 1'b1;
         cur_in  = IDX_W'(1);
      end else if (chk_ff && match) begin
         busy_in  = 1'b0;
         rsp.done = 1'b1;
         rsp.hit  = 1'b1;
      end else if (chk_ff && !busy_ff) begin
         rsp.done = 1'b1;
      end else if (busy_ff) begin
         chk_in = 1'b1;
         if (last)
            busy_in = 1'b0;
         else
            cur_in = cur_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         chk_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         chk_ff  <= chk_in;
      end
      cur_ff     <= cur_in;
      chk_tag_ff <= chk_tag_in;
   end

endmodule

@@ design/grrt_checker.sv @@
module grrt_checker
   import grrt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_ok,
   input logic [3:0]  rsp_status,
   input logic [31:0] rsp_reference_out,
   input logic [63:0] rsp_host_address_out
);

   a_str_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("strobe without work");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("double strobe");

   a_ref_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> (rsp_reference_out == 32'd0
                                  && rsp_host_address_out == 64'd0))
      else $error("payload on failure");

   a_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_ok) |-> (rsp_status == ST_OK || rsp_status == ST_NULL))
      else $error("ok with error status");

endmodule

bind guest_reference_region_table_unit grrt_checker u_grrt_checker (.*);
